// ===== hdl/pprank_pkg.sv =====
// Package for the personalised PageRank block: sizes, item codes and state type.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none
package pprank_pkg;

	localparam int MAX_V   = 1024;
	localparam int VW      = $clog2(MAX_V);
	localparam int NVW     = VW + 1;
	localparam int MAX_E   = 8192;
	localparam int EW      = $clog2(MAX_E);
	localparam int ECW     = EW + 1;
	localparam int DEGW    = ECW;
	localparam int VALW    = 32;
	localparam int DAMPW   = 16;
	localparam int PRODW   = VALW + DAMPW;
	localparam int ITW     = 8;
	localparam int DCW     = $clog2(VALW);

	typedef logic [2:0] mode_t;
	localparam mode_t MODE_PREF  = 3'd0;
	localparam mode_t MODE_EDGE  = 3'd1;
	localparam mode_t MODE_RUN   = 3'd2;
	localparam mode_t MODE_READ  = 3'd3;
	localparam mode_t MODE_CLEAR = 3'd4;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_RANGE = 2'd2;

	localparam logic [1:0] REG_VCOUNT = 2'd0;
	localparam logic [1:0] REG_DAMP   = 2'd1;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_INIT,
		S_E0,
		S_E1,
		S_E2,
		S_E3,
		S_DIV,
		S_E4
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/personalized_pagerank_iteration.sv =====
// Personalised PageRank, Jacobi power iteration over on-chip vertex and edge memories.
// Load and read items: via stage s1 to the output register, one item per cycle while idle and the output is free.
// Run item: a clear pass over both rank banks, then per sweep a preference copy into the next bank
// and, per stored edge, a division through the 32-step serial divider (a skipped edge bypasses it).
// Clear item: a pass over preferences and degrees.
// Reset: a clearing pass over all vertex memories, input held off meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module personalized_pagerank_iteration
	import pprank_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // vertex, target, pref_value, iterations, zero pad
	input  wire logic [2:0]  s_tuser,   // mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // vertex_out, rank_value, zero pad
	output logic [1:0]       m_tuser,   // status
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	// memories
	logic [VALW-1:0]   pref_mem [MAX_V];
	logic [DEGW-1:0]   deg_mem  [MAX_V];
	logic [2*VW-1:0]   edge_mem [MAX_E];
	logic [VALW-1:0]   a_mem    [MAX_V];
	logic [VALW-1:0]   b_mem    [MAX_V];

	logic [VALW-1:0] pref_rd_q, a_rd_q, b_rd_q;
	logic [DEGW-1:0] deg_rd_q;
	logic [2*VW-1:0] edge_rd_q;

	logic            pref_we, pref_re, deg_we, deg_re, edge_we, edge_re;
	logic            a_we, a_re, b_we, b_re;
	logic [VW-1:0]   pref_wa, pref_ra, deg_wa, deg_ra, a_wa, a_ra, b_wa, b_ra;
	logic [EW-1:0]   edge_wa, edge_ra;
	logic [VALW-1:0] pref_wd, a_wd, b_wd;
	logic [DEGW-1:0] deg_wd;
	logic [2*VW-1:0] edge_wd;

	// control
	state_t          state_q, state_d;
	logic [NVW-1:0]  cnt_q, vcount_q, nv;
	logic            clr_graph_q, clr_banks_q, run_q, sel_q, ip_v_q;
	logic [ITW-1:0]  iter_q;
	logic [ECW-1:0]  e_q, edge_cnt_q;
	logic [DAMPW-1:0] damp_q;
	logic [VW-1:0]   ip_a_q, src_q, dst_q;
	logic [PRODW-1:0] prod_q;
	logic [VALW-1:0] nval_q, quo_q;
	logic [DEGW-1:0] degv_q, rem_q;
	logic [DCW-1:0]  dcnt_q;

	// result path
	logic            v_s1, rdp_s1, rdsel_s1, edge_s1, fwd_s1;
	status_t         status_s1;
	logic [VW-1:0]   vtx_s1;
	logic [VALW-1:0] rank_s1;
	logic [DEGW-1:0] fwdval_s1;
	logic            m_tvalid_q;
	status_t         status_q;
	logic [VW-1:0]   vtxo_q;
	logic [VALW-1:0] rank_q;

	// input fields
	mode_t           in_mode;
	logic [VW-1:0]   in_vtx, in_tgt;
	logic [VALW-1:0] in_pref;
	logic [ITW-1:0]  in_iter;
	logic            acc, out_free, s1_move, vtx_ok, tgt_ok, edge_full;
	status_t         in_status;
	logic            in_edge_ok, in_read_ok;

	logic [VALW-1:0] old_rd, nxt_rd, rd_bank;
	logic [DEGW-1:0] deg_inc;
	logic            init_done, clr_last, edge_ok;
	logic [DEGW:0]   rem_sh;
	logic            div_ge;
	logic [VALW:0]   sum;
	logic [VALW-1:0] sat;

	assign in_mode = s_tuser;
	assign in_vtx  = s_tdata[VW-1:0];
	assign in_tgt  = s_tdata[2*VW-1:VW];
	assign in_pref = s_tdata[2*VW+VALW-1:2*VW];
	assign in_iter = s_tdata[2*VW+VALW+ITW-1:2*VW+VALW];

	assign nv = (vcount_q > NVW'(MAX_V)) ? NVW'(MAX_V) : vcount_q;
	assign vtx_ok = {1'b0, in_vtx} < nv;
	assign tgt_ok = {1'b0, in_tgt} < nv;
	assign edge_full = edge_cnt_q == ECW'(MAX_E);

	assign out_free = !m_tvalid_q || m_tready;
	assign s1_move  = v_s1 && out_free;
	assign s_tready = (state_q == S_IDLE) && (!v_s1 || out_free);
	assign acc      = s_tvalid && s_tready;
	// registers held while a run or clear pass is under way
	assign cfg_ready = state_q == S_IDLE;

	always_comb begin
		in_status  = ST_OK;
		in_edge_ok = 1'b0;
		in_read_ok = 1'b0;
		case (in_mode)
			MODE_PREF: begin
				if (!vtx_ok) in_status = ST_RANGE;
			end
			MODE_EDGE: begin
				if (!(vtx_ok && tgt_ok)) in_status = ST_RANGE;
				else if (edge_full) in_status = ST_FULL;
				else in_edge_ok = 1'b1;
			end
			MODE_READ: begin
				if (!vtx_ok) in_status = ST_RANGE;
				else in_read_ok = 1'b1;
			end
			default: ;
		endcase
	end

	assign old_rd  = sel_q ? b_rd_q : a_rd_q;
	assign nxt_rd  = sel_q ? a_rd_q : b_rd_q;
	assign rd_bank = rdsel_s1 ? b_rd_q : a_rd_q;
	assign deg_inc = (fwd_s1 ? fwdval_s1 : deg_rd_q) + DEGW'(1);

	assign init_done = (cnt_q >= nv) && !ip_v_q;
	assign clr_last  = cnt_q[VW-1:0] == VW'(MAX_V - 1);
	assign edge_ok   = ({1'b0, src_q} < nv) && ({1'b0, dst_q} < nv) && (deg_rd_q != '0);

	assign rem_sh = {rem_q, quo_q[VALW-1]};
	assign div_ge = rem_sh >= {1'b0, degv_q};
	assign sum    = {1'b0, nval_q} + {1'b0, quo_q};
	assign sat    = sum[VALW] ? '1 : sum[VALW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				if (clr_last) begin
					if (run_q && iter_q != '0) state_d = S_INIT;
					else state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (acc && (in_mode == MODE_RUN || in_mode == MODE_CLEAR)) state_d = S_CLR;
			end
			S_INIT: if (init_done) state_d = S_E0;
			S_E0: begin
				if (e_q == edge_cnt_q) state_d = (iter_q == ITW'(1)) ? S_IDLE : S_INIT;
				else state_d = S_E1;
			end
			S_E1: state_d = S_E2;
			S_E2: state_d = edge_ok ? S_E3 : S_E0;
			S_E3: state_d = S_DIV;
			S_DIV: if (dcnt_q == '0) state_d = S_E4;
			S_E4: state_d = S_E0;
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		pref_we = 1'b0; pref_wa = in_vtx; pref_wd = in_pref;
		pref_re = 1'b0; pref_ra = cnt_q[VW-1:0];
		deg_we  = 1'b0; deg_wa = vtx_s1; deg_wd = deg_inc;
		deg_re  = 1'b0; deg_ra = in_vtx;
		edge_we = 1'b0; edge_wa = edge_cnt_q[EW-1:0]; edge_wd = {in_vtx, in_tgt};
		edge_re = 1'b0; edge_ra = e_q[EW-1:0];
		a_we = 1'b0; a_wa = cnt_q[VW-1:0]; a_wd = '0; a_re = 1'b0; a_ra = in_vtx;
		b_we = 1'b0; b_wa = cnt_q[VW-1:0]; b_wd = '0; b_re = 1'b0; b_ra = in_vtx;
		unique case (state_q)
			S_CLR: begin
				if (clr_graph_q) begin
					pref_we = 1'b1; pref_wa = cnt_q[VW-1:0]; pref_wd = '0;
					deg_we  = 1'b1; deg_wa = cnt_q[VW-1:0]; deg_wd = '0;
				end
				if (clr_banks_q) begin
					a_we = 1'b1;
					b_we = 1'b1;
				end
			end
			S_IDLE: begin
				if (acc && in_mode == MODE_PREF && in_status == ST_OK) pref_we = 1'b1;
				if (acc && in_edge_ok) edge_we = 1'b1;
				if (acc && in_mode == MODE_EDGE) deg_re = 1'b1;
				if (acc && in_read_ok) begin
					if (sel_q) b_re = 1'b1;
					else a_re = 1'b1;
				end
			end
			S_INIT: begin
				pref_re = cnt_q < nv;
				if (ip_v_q) begin
					if (sel_q) begin
						a_we = 1'b1; a_wa = ip_a_q; a_wd = pref_rd_q;
					end else begin
						b_we = 1'b1; b_wa = ip_a_q; b_wd = pref_rd_q;
					end
				end
			end
			S_E0: edge_re = e_q != edge_cnt_q;
			S_E1: begin
				deg_re = 1'b1;
				deg_ra = edge_rd_q[2*VW-1:VW];
				a_re = 1'b1;
				b_re = 1'b1;
				if (sel_q) begin
					b_ra = edge_rd_q[2*VW-1:VW];
					a_ra = edge_rd_q[VW-1:0];
				end else begin
					a_ra = edge_rd_q[2*VW-1:VW];
					b_ra = edge_rd_q[VW-1:0];
				end
			end
			S_E4: begin
				if (sel_q) begin
					a_we = 1'b1; a_wa = dst_q; a_wd = sat;
				end else begin
					b_we = 1'b1; b_wa = dst_q; b_wd = sat;
				end
			end
			default: ;
		endcase
		if (s1_move && edge_s1) deg_we = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (pref_we) pref_mem[pref_wa] <= pref_wd;
		if (pref_re) pref_rd_q <= pref_mem[pref_ra];
		if (deg_we) deg_mem[deg_wa] <= deg_wd;
		if (deg_re) deg_rd_q <= deg_mem[deg_ra];
		if (edge_we) edge_mem[edge_wa] <= edge_wd;
		if (edge_re) edge_rd_q <= edge_mem[edge_ra];
		if (a_we) a_mem[a_wa] <= a_wd;
		if (a_re) a_rd_q <= a_mem[a_ra];
		if (b_we) b_mem[b_wa] <= b_wd;
		if (b_re) b_rd_q <= b_mem[b_ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cnt_q       <= '0;
			clr_graph_q <= 1'b1;
			clr_banks_q <= 1'b1;
			run_q       <= 1'b0;
			iter_q      <= '0;
			sel_q       <= 1'b0;
			e_q         <= '0;
			edge_cnt_q  <= '0;
			vcount_q    <= NVW'(MAX_V);
			damp_q      <= DAMPW'(55706);
			ip_v_q      <= 1'b0;
			v_s1        <= 1'b0;
			rdp_s1      <= 1'b0;
			edge_s1     <= 1'b0;
			fwd_s1      <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready && cfg_index == REG_VCOUNT)
				vcount_q <= cfg_data[NVW-1:0];
			if (cfg_valid && cfg_ready && cfg_index == REG_DAMP) damp_q <= cfg_data;

			unique case (state_q)
				S_CLR: cnt_q <= clr_last ? '0 : cnt_q + NVW'(1);
				S_IDLE: begin
					if (acc && in_mode == MODE_RUN) begin
						cnt_q       <= '0;
						clr_graph_q <= 1'b0;
						clr_banks_q <= 1'b1;
						run_q       <= 1'b1;
						iter_q      <= in_iter;
						sel_q       <= 1'b0;
					end
					if (acc && in_mode == MODE_CLEAR) begin
						cnt_q       <= '0;
						clr_graph_q <= 1'b1;
						clr_banks_q <= 1'b0;
						run_q       <= 1'b0;
						edge_cnt_q  <= '0;
					end
					if (acc && in_edge_ok) edge_cnt_q <= edge_cnt_q + ECW'(1);
				end
				S_INIT: begin
					ip_v_q <= cnt_q < nv;
					if (cnt_q < nv) cnt_q <= cnt_q + NVW'(1);
					e_q <= '0;
				end
				S_E0: begin
					if (e_q == edge_cnt_q) begin
						sel_q  <= !sel_q;
						iter_q <= iter_q - ITW'(1);
						cnt_q  <= '0;
					end
				end
				S_E2: if (!edge_ok) e_q <= e_q + ECW'(1);
				S_E4: e_q <= e_q + ECW'(1);
				default: ;
			endcase

			if (acc) begin
				v_s1    <= 1'b1;
				rdp_s1  <= in_read_ok;
				edge_s1 <= in_edge_ok;
				fwd_s1  <= s1_move && edge_s1 && (vtx_s1 == in_vtx);
			end else begin
				if (s1_move) v_s1 <= 1'b0;
				if (rdp_s1) rdp_s1 <= 1'b0;
				if (s1_move) edge_s1 <= 1'b0;
			end

			if (s1_move) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_INIT) ip_a_q <= cnt_q[VW-1:0];
		if (state_q == S_E1) begin
			src_q <= edge_rd_q[2*VW-1:VW];
			dst_q <= edge_rd_q[VW-1:0];
		end
		if (state_q == S_E2) begin
			degv_q <= deg_rd_q;
			nval_q <= nxt_rd;
			prod_q <= PRODW'(old_rd) * PRODW'(damp_q);
		end
		if (state_q == S_E3) begin
			quo_q  <= prod_q[PRODW-1:DAMPW];
			rem_q  <= '0;
			dcnt_q <= DCW'(VALW - 1);
		end
		if (state_q == S_DIV) begin
			rem_q  <= div_ge ? DEGW'(rem_sh - {1'b0, degv_q}) : rem_sh[DEGW-1:0];
			quo_q  <= {quo_q[VALW-2:0], div_ge};
			dcnt_q <= dcnt_q - DCW'(1);
		end

		if (acc) begin
			status_s1 <= in_status;
			vtx_s1    <= in_vtx;
			rank_s1   <= '0;
			rdsel_s1  <= sel_q;
			fwdval_s1 <= deg_inc;
		end else if (rdp_s1 && !s1_move) begin
			rank_s1 <= rd_bank;
		end

		if (s1_move) begin
			status_q <= status_s1;
			vtxo_q   <= vtx_s1;
			rank_q   <= rdp_s1 ? rd_bank : rank_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {6'd0, rank_q, vtxo_q};

endmodule
`default_nettype wire

// ===== hdl/pprank_checker.sv =====
// Port-level checks for the personalised PageRank block, bound to its top level.
// Depends on pprank_pkg for item and status codes.
`timescale 1ns / 1ps
`default_nettype none
module pprank_checker
	import pprank_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [2:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result request changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_FULL || m_tuser == ST_RANGE))
		else $error("undefined status");

	a_err_rank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata[41:10] == '0)
		else $error("rank on failed request");

	a_long_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_RUN || s_tuser == MODE_CLEAR) |=> !s_tready)
		else $error("input taken during run or clear pass");

endmodule

bind personalized_pagerank_iteration pprank_checker u_pprank_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
